// ===== rtl/core/srls_pkg.sv =====
// ----------------------------------------------------------------------------
// srls_pkg
// Types and constants shared by the slot registry with lifo sweep.
// ----------------------------------------------------------------------------
package srls_pkg;

    localparam int OPCODE_W = 2;
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 64;
    localparam int ORDER_W  = 64;
    localparam int HANDLE_W = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OPCODE_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SWEEP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_ONE = 64'd1;
    localparam logic [ORDER_W-1:0] ORDER_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] res_ref;
        logic [DATA_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        t_entry              entry;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

endpackage

// ===== rtl/core/slot_registry_lifo_sweep_unit.sv =====
// ----------------------------------------------------------------------------
// slot_registry_lifo_sweep_unit
// Slot table with lowest-free allocation, release by handle and a sweep that
// returns every live entry newest first, one compare per cycle.
// ----------------------------------------------------------------------------
// register: lowest-free search in S_FIND, one slot tested per cycle
// release and empty sweep: decided in S_IDLE, result beat staged from S_EMIT
// sweep: per live entry, a serial order scan over every slot, then S_FETCH, S_PUT and S_EMIT
// one item at a time; input stalls until the last result beat is staged
// reset: all slots dead, sequence counter 1, no clearing pass
// ----------------------------------------------------------------------------
module slot_registry_lifo_sweep_unit #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [srls_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [srls_pkg::KIND_W-1:0]   i_res_kind,
    input  logic [srls_pkg::DATA_W-1:0]   i_res_ref,
    input  logic [srls_pkg::DATA_W-1:0]   i_release_tag,
    input  logic [srls_pkg::HANDLE_W-1:0] i_slot_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [srls_pkg::HANDLE_W-1:0] o_out_handle,
    output logic [srls_pkg::KIND_W-1:0]   o_out_kind,
    output logic [srls_pkg::DATA_W-1:0]   o_out_ref,
    output logic [srls_pkg::DATA_W-1:0]   o_out_tag,
    output logic [srls_pkg::STATUS_W-1:0] o_status,
    output logic [srls_pkg::COUNT_W-1:0]  o_live_count,
    output logic                          o_last
);
    import srls_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
    localparam logic [HANDLE_W-1:0] MAX_HANDLE = HANDLE_W'(SLOT_COUNT);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIND     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SCAN_END = 3'd3;
    localparam logic [2:0] S_FETCH    = 3'd4;
    localparam logic [2:0] S_PUT      = 3'd5;
    localparam logic [2:0] S_EMIT     = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [SLOT_COUNT-1:0] r_live, n_live;
    logic [COUNT_W-1:0]    r_live_total, n_live_total;
    logic [ORDER_W-1:0]    r_next_order, n_next_order;
    t_entry                r_in_entry, n_in_entry;
    logic                  r_cmp_v, n_cmp_v;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic                  r_best_v, n_best_v;
    logic [IDX_W-1:0]      r_best_idx, n_best_idx;
    logic [ORDER_W-1:0]    r_best_ord, n_best_ord;
    t_result               r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;
    logic [COUNT_W-1:0]    r_out_live, n_out_live;

    logic [ORDER_W-1:0]    r_order_mem [SLOT_COUNT];
    t_entry                r_data_mem [SLOT_COUNT];
    logic [ORDER_W-1:0]    r_ord_q;
    t_entry                r_data_q;

    logic                  w_we;
    logic                  w_out_free;
    logic [HANDLE_W-1:0]   w_hm1;
    logic [IDX_W-1:0]      w_rel_idx;
    t_result               w_blank;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_hm1      = i_slot_handle - HANDLE_W'(1);
    assign w_rel_idx  = w_hm1[IDX_W-1:0];

    always_comb begin
        w_blank.handle = '0;
        w_blank.entry  = '0;
        w_blank.status = ST_OK;
        w_blank.last   = 1'b1;
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_order_mem[r_idx] <= r_next_order;
            r_data_mem[r_idx]  <= r_in_entry;
        end
        r_ord_q  <= r_order_mem[r_idx];
        r_data_q <= r_data_mem[r_best_idx];
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_live       = r_live;
        n_live_total = r_live_total;
        n_next_order = r_next_order;
        n_in_entry   = r_in_entry;
        n_cmp_v      = r_cmp_v;
        n_cmp_idx    = r_cmp_idx;
        n_best_v     = r_best_v;
        n_best_idx   = r_best_idx;
        n_best_ord   = r_best_ord;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_out_live   = r_out_live;
        w_we         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // newest-order compare, strict so ties keep the lowest slot
        if ((r_state == S_SCAN || r_state == S_SCAN_END) && r_cmp_v &&
            (!r_best_v || r_ord_q > r_best_ord)) begin
            n_best_v   = 1'b1;
            n_best_idx = r_cmp_idx;
            n_best_ord = r_ord_q;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in_entry.kind    = i_res_kind;
                    n_in_entry.res_ref = i_res_ref;
                    n_in_entry.tag     = i_release_tag;
                    n_idx              = '0;
                    n_pend             = w_blank;
                    n_state            = S_EMIT;
                    unique case (i_opcode)
                        OP_REGISTER: begin
                            n_state = S_FIND;
                        end
                        OP_RELEASE: begin
                            if (i_slot_handle == '0 || i_slot_handle > MAX_HANDLE) begin
                                n_pend.status = ST_IGNORED;
                            end else if (r_live[w_rel_idx]) begin
                                n_live[w_rel_idx] = 1'b0;
                                n_live_total      = r_live_total - COUNT_W'(1);
                            end
                        end
                        OP_SWEEP: begin
                            n_next_order = ORDER_ONE;
                            if (r_live_total == '0) begin
                                n_pend.status = ST_EMPTY;
                            end else begin
                                n_state  = S_SCAN;
                                n_best_v = 1'b0;
                                n_cmp_v  = 1'b0;
                            end
                        end
                        default: begin
                            n_pend.status = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (!r_live[r_idx]) begin
                    w_we          = 1'b1;
                    n_live[r_idx] = 1'b1;
                    n_live_total  = r_live_total + COUNT_W'(1);
                    if (r_next_order != ORDER_MAX) begin
                        n_next_order = r_next_order + ORDER_ONE;
                    end
                    n_pend.handle = HANDLE_W'(r_idx) + HANDLE_W'(1);
                    n_state       = S_EMIT;
                end else if (r_idx == LAST_IDX) begin
                    n_pend.status = ST_FULL;
                    n_state       = S_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN: begin
                n_cmp_v   = r_live[r_idx];
                n_cmp_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SCAN_END: begin
                n_cmp_v = 1'b0;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_PUT;
            end
            S_PUT: begin
                n_live[r_best_idx] = 1'b0;
                n_live_total       = r_live_total - COUNT_W'(1);
                n_pend.handle      = HANDLE_W'(r_best_idx) + HANDLE_W'(1);
                n_pend.entry       = r_data_q;
                n_pend.status      = ST_OK;
                n_pend.last        = (r_live_total == COUNT_W'(1));
                n_state            = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_out_live  = r_live_total;
                    if (r_pend.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state  = S_SCAN;
                        n_idx    = '0;
                        n_best_v = 1'b0;
                        n_cmp_v  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_live       <= '0;
            r_live_total <= '0;
            r_next_order <= ORDER_ONE;
            r_cmp_v      <= 1'b0;
            r_best_v     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live       <= n_live;
            r_live_total <= n_live_total;
            r_next_order <= n_next_order;
            r_cmp_v      <= n_cmp_v;
            r_best_v     <= n_best_v;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_in_entry <= n_in_entry;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best_ord <= n_best_ord;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_live <= n_out_live;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out.handle;
    assign o_out_kind   = r_out.entry.kind;
    assign o_out_ref    = r_out.entry.res_ref;
    assign o_out_tag    = r_out.entry.tag;
    assign o_status     = r_out.status;
    assign o_live_count = r_out_live;
    assign o_last       = r_out.last;

endmodule

// ===== tb/slot_registry_lifo_sweep_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_registry_lifo_sweep_unit_test
// Feeds register, release and sweep items into the slot registry. A shadow
// copy of the slot table predicts every result beat, and each beat is checked
// field by field. A short table of hand-checked items runs first. Random
// phases follow, with sender gaps and receiver stalls, two full-table fills,
// a long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module slot_registry_lifo_sweep_unit_test;
    import srls_pkg::*;

    localparam int SLOT_COUNT     = 64;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PER_PHASE = 45;
    localparam int MAX_REPORTS    = 40;
    localparam int QUIET_LIMIT    = 4 * (HOLD_CYCLES + 2 * SLOT_COUNT + 8);
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0]   ALL_ONES  = '1;
    localparam logic [DATA_W-1:0]   ALT_A     = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [DATA_W-1:0]   ALT_5     = 64'h5555_5555_5555_5555;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   res_ref;
        logic [DATA_W-1:0]   tag;
        logic [HANDLE_W-1:0] handle;
    } t_op;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]   kind;
        logic [DATA_W-1:0]   res_ref;
        logic [DATA_W-1:0]   tag;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live;
        logic                last;
    } t_beat;

    typedef struct packed {
        t_op                 op;
        logic                typed;
        logic [HANDLE_W-1:0] e_handle;
        logic [STATUS_W-1:0] e_status;
        logic [COUNT_W-1:0]  e_live;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [OPCODE_W-1:0] i_opcode;
    logic [KIND_W-1:0]   i_res_kind;
    logic [DATA_W-1:0]   i_res_ref;
    logic [DATA_W-1:0]   i_release_tag;
    logic [HANDLE_W-1:0] i_slot_handle;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [HANDLE_W-1:0] o_out_handle;
    logic [KIND_W-1:0]   o_out_kind;
    logic [DATA_W-1:0]   o_out_ref;
    logic [DATA_W-1:0]   o_out_tag;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_live_count;
    logic                o_last;

    slot_registry_lifo_sweep_unit #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_res_kind   (i_res_kind),
        .i_res_ref    (i_res_ref),
        .i_release_tag(i_release_tag),
        .i_slot_handle(i_slot_handle),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_handle (o_out_handle),
        .o_out_kind   (o_out_kind),
        .o_out_ref    (o_out_ref),
        .o_out_tag    (o_out_tag),
        .o_status     (o_status),
        .o_live_count (o_live_count),
        .o_last       (o_last)
    );

    // shadow slot table
    logic [ORDER_W-1:0]  seq_of  [SLOT_COUNT];
    logic [KIND_W-1:0]   kind_of [SLOT_COUNT];
    logic [DATA_W-1:0]   ref_of  [SLOT_COUNT];
    logic [DATA_W-1:0]   tag_of  [SLOT_COUNT];
    logic [ORDER_W-1:0]  next_seq;
    logic [COUNT_W-1:0]  live_now;

    t_beat owed_beats[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int error_count;
    int items_sent;
    int beats_checked;
    int full_answers;
    int widest_sweep;

    t_row plan [20] = '{
        '{'{OP_SWEEP,    2'd0, 64'd0,    64'd0,    7'd0},   1'b1, 7'd0, ST_EMPTY,   7'd0},
        '{'{OP_RELEASE,  2'd0, 64'd0,    64'd0,    7'd0},   1'b1, 7'd0, ST_IGNORED, 7'd0},
        '{'{OP_RELEASE,  2'd1, 64'd0,    64'd0,    7'd65},  1'b1, 7'd0, ST_IGNORED, 7'd0},
        '{'{OP_RELEASE,  2'd2, 64'd0,    64'd0,    7'd127}, 1'b1, 7'd0, ST_IGNORED, 7'd0},
        '{'{OP_UNUSED,   2'd3, ALL_ONES, ALL_ONES, 7'd127}, 1'b1, 7'd0, ST_IGNORED, 7'd0},
        '{'{OP_REGISTER, 2'd0, 64'd0,    64'd0,    7'd0},   1'b1, 7'd1, ST_OK,      7'd1},
        '{'{OP_REGISTER, 2'd3, ALL_ONES, ALL_ONES, 7'd127}, 1'b1, 7'd2, ST_OK,      7'd2},
        '{'{OP_REGISTER, 2'd1, ALT_5,    ALT_A,    7'd0},   1'b1, 7'd3, ST_OK,      7'd3},
        '{'{OP_REGISTER, 2'd2, ALT_A,    ALT_5,    7'd0},   1'b1, 7'd4, ST_OK,      7'd4},
        '{'{OP_RELEASE,  2'd0, 64'd0,    64'd0,    7'd2},   1'b1, 7'd0, ST_OK,      7'd3},
        '{'{OP_RELEASE,  2'd0, 64'd0,    64'd0,    7'd2},   1'b1, 7'd0, ST_OK,      7'd3},
        '{'{OP_REGISTER, 2'd3, 64'd1,    {1'b1, 63'd0}, 7'd0}, 1'b1, 7'd2, ST_OK,   7'd4},
        '{'{OP_RELEASE,  2'd0, 64'd0,    64'd0,    7'd64},  1'b1, 7'd0, ST_OK,      7'd4},
        '{'{OP_RELEASE,  2'd0, 64'd0,    64'd0,    7'd1},   1'b1, 7'd0, ST_OK,      7'd3},
        '{'{OP_REGISTER, 2'd1, 64'h1234_5678_9ABC_DEF0, 64'd7, 7'd0},
                                                            1'b1, 7'd1, ST_OK,      7'd4},
        '{'{OP_SWEEP,    2'd0, 64'd0,    64'd0,    7'd0},   1'b0, 7'd0, ST_OK,      7'd0},
        '{'{OP_SWEEP,    2'd1, 64'd0,    64'd0,    7'd0},   1'b1, 7'd0, ST_EMPTY,   7'd0},
        '{'{OP_REGISTER, 2'd2, 64'd9,    64'd0,    7'd0},   1'b1, 7'd1, ST_OK,      7'd1},
        '{'{OP_REGISTER, 2'd0, 64'd10,   64'd11,   7'd0},   1'b1, 7'd2, ST_OK,      7'd2},
        '{'{OP_SWEEP,    2'd0, 64'd0,    64'd0,    7'd0},   1'b0, 7'd0, ST_OK,      7'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        end
    endtask

    // shadow table update; pushes the beats this item causes
    task automatic apply_registry_op(input t_op op);
        t_beat b;
        int    pick;
        int    beats;
        b      = '0;
        b.last = 1'b1;
        pick   = -1;
        beats  = 0;
        case (op.opcode)
            OP_REGISTER: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (pick < 0 && seq_of[i] == '0) pick = i;
                end
                if (pick < 0) begin
                    b.status = ST_FULL;
                    full_answers++;
                end else begin
                    kind_of[pick] = op.kind;
                    ref_of[pick]  = op.res_ref;
                    tag_of[pick]  = op.tag;
                    seq_of[pick]  = next_seq;
                    if (next_seq != ORDER_MAX) next_seq++;
                    live_now++;
                    b.handle = HANDLE_W'(pick + 1);
                    b.status = ST_OK;
                end
                b.live = live_now;
                owed_beats.push_back(b);
            end
            OP_RELEASE: begin
                if (op.handle == '0 || op.handle > SLOT_COUNT) begin
                    b.status = ST_IGNORED;
                end else begin
                    if (seq_of[op.handle - 1] != '0) begin
                        seq_of[op.handle - 1] = '0;
                        live_now--;
                    end
                    b.status = ST_OK;
                end
                b.live = live_now;
                owed_beats.push_back(b);
            end
            OP_SWEEP: begin
                next_seq = ORDER_ONE;
                if (live_now == '0) begin
                    b.status = ST_EMPTY;
                    owed_beats.push_back(b);
                end
                while (live_now != '0) begin
                    pick = -1;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (seq_of[i] != '0 && (pick < 0 || seq_of[i] > seq_of[pick])) pick = i;
                    end
                    seq_of[pick] = '0;
                    live_now--;
                    b.handle  = HANDLE_W'(pick + 1);
                    b.kind    = kind_of[pick];
                    b.res_ref = ref_of[pick];
                    b.tag     = tag_of[pick];
                    b.status  = ST_OK;
                    b.live    = live_now;
                    b.last    = (live_now == '0);
                    owed_beats.push_back(b);
                    beats++;
                end
                if (beats > widest_sweep) widest_sweep = beats;
            end
            default: begin
                b.status = ST_IGNORED;
                b.live   = live_now;
                owed_beats.push_back(b);
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_op fresh_entry();
        t_op op;
        op.opcode  = OP_REGISTER;
        op.kind    = KIND_W'($urandom_range(3));
        op.res_ref = rand_word();
        op.tag     = rand_word();
        op.handle  = HANDLE_W'($urandom_range(127));
        return op;
    endfunction

    function automatic t_op random_op();
        t_op op;
        int  roll;
        op   = fresh_entry();
        roll = $urandom_range(99);
        if (roll < 45) begin
            op.opcode = OP_REGISTER;
        end else if (roll < 75) begin
            // mostly aim at a live slot
            op.opcode = OP_RELEASE;
            op.handle = HANDLE_W'($urandom_range(SLOT_COUNT, 1));
            for (int t = 0; t < 8 && seq_of[op.handle - 1] == '0; t++) begin
                op.handle = HANDLE_W'($urandom_range(SLOT_COUNT, 1));
            end
        end else if (roll < 83) begin
            op.opcode = OP_RELEASE;
        end else if (roll < 95) begin
            op.opcode = OP_SWEEP;
        end else begin
            op.opcode = OP_UNUSED;
        end
        return op;
    endfunction

    // present one beat, hold it until accepted, then predict
    task automatic offer(input t_op op, input logic typed = 1'b0,
                         input t_beat want = '0);
        @(negedge i_clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op.opcode;
        i_res_kind    <= op.kind;
        i_res_ref     <= op.res_ref;
        i_release_tag <= op.tag;
        i_slot_handle <= op.handle;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        apply_registry_op(op);
        if (typed) begin
            void'(owed_beats.pop_back());
            owed_beats.push_back(want);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (owed_beats.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, or a counted hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                n        = hold_req;
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_checked++;
            if (owed_beats.size() == 0) begin
                flag_mismatch("beat with nothing owed, handle", 64'(o_out_handle), 64'd0);
            end else begin
                want = owed_beats.pop_front();
                if (o_out_handle !== want.handle)
                    flag_mismatch("handle", 64'(o_out_handle), 64'(want.handle));
                if (o_out_kind !== want.kind)
                    flag_mismatch("kind", 64'(o_out_kind), 64'(want.kind));
                if (o_out_ref !== want.res_ref)
                    flag_mismatch("ref", o_out_ref, want.res_ref);
                if (o_out_tag !== want.tag)
                    flag_mismatch("tag", o_out_tag, want.tag);
                if (o_status !== want.status)
                    flag_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_live_count !== want.live)
                    flag_mismatch("live count", 64'(o_live_count), 64'(want.live));
                if (o_last !== want.last)
                    flag_mismatch("last", 64'(o_last), 64'(want.last));
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("slot_registry_lifo_sweep_unit_test failed");
        $finish;
    end

    initial begin
        t_beat want;
        t_op   op;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = OP_REGISTER;
        i_res_kind     = '0;
        i_res_ref      = '0;
        i_release_tag  = '0;
        i_slot_handle  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        error_count    = 0;
        items_sent     = 0;
        beats_checked  = 0;
        full_answers   = 0;
        widest_sweep   = 0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            seq_of[i]  = '0;
            kind_of[i] = '0;
            ref_of[i]  = '0;
            tag_of[i]  = '0;
        end
        next_seq = ORDER_ONE;
        live_now = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            want        = '0;
            want.handle = plan[r].e_handle;
            want.status = plan[r].e_status;
            want.live   = plan[r].e_live;
            want.last   = 1'b1;
            offer(plan[r].op, plan[r].typed, want);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (phase == 0) hold_req = HOLD_CYCLES;
            if (phase == 0 || phase == 3) begin
                // fill the table, overflow it, refill one slot, sweep it all
                while (live_now < SLOT_COUNT) offer(fresh_entry());
                repeat (2) offer(fresh_entry());
                op        = fresh_entry();
                op.opcode = OP_RELEASE;
                op.handle = HANDLE_W'($urandom_range(SLOT_COUNT, 1));
                offer(op);
                offer(fresh_entry());
                op.opcode = OP_SWEEP;
                offer(op);
            end
            repeat (RAND_PER_PHASE) offer(random_op());
            wait_drained();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (2 * SLOT_COUNT + 8) @(posedge i_clk);
        if (owed_beats.size() != 0)
            flag_mismatch("beats still owed", 64'(owed_beats.size()), 64'd0);

        $display("covered %0d items and %0d result beats, %0d table-full answers",
                 items_sent, beats_checked, full_answers);
        $display("largest sweep %0d entries, %0d mismatches", widest_sweep, error_count);
        if (error_count == 0) begin
            $display("slot_registry_lifo_sweep_unit_test passed");
        end else begin
            $display("slot_registry_lifo_sweep_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== slot_registry_lifo_sweep_unit.f =====
rtl/core/srls_pkg.sv
rtl/core/slot_registry_lifo_sweep_unit.sv
tb/slot_registry_lifo_sweep_unit_test.sv
